>>> rtl/vpc_pkg.sv
// shared types, constants and tables of the voxel phase colourizer
package vpc_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = 62;
    localparam int COORD_W      = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_COORD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_RADIUS = 3'd6;

    typedef enum logic [1:0]
    {
        SLICE_FULL = 2'd0,
        SLICE_XY   = 2'd1,
        SLICE_YZ   = 2'd2,
        SLICE_ZX   = 2'd3
    } slice_t;

    typedef enum logic [2:0]
    {
        OV_NONE  = 3'd0,
        OV_WHITE = 3'd1,
        OV_GREEN = 3'd2,
        OV_RED   = 3'd3,
        OV_HIDE  = 3'd4
    } ovl_t;

    typedef struct packed
    {
        ovl_t ov;
        logic hue_en;
    } side_t;

    typedef struct packed
    {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic        [31:0]     acc;
        side_t                  side;
    } cordic_t;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] t;
        begin
            unique case (step)
                0:  t = 32'd536870912;
                1:  t = 32'd316933406;
                2:  t = 32'd167458907;
                3:  t = 32'd85004756;
                4:  t = 32'd42667331;
                5:  t = 32'd21354465;
                6:  t = 32'd10679838;
                7:  t = 32'd5340245;
                8:  t = 32'd2670163;
                9:  t = 32'd1335087;
                10: t = 32'd667544;
                11: t = 32'd333772;
                12: t = 32'd166886;
                13: t = 32'd83443;
                14: t = 32'd41722;
                15: t = 32'd20861;
                16: t = 32'd10430;
                17: t = 32'd5215;
                18: t = 32'd2608;
                19: t = 32'd1304;
                20: t = 32'd652;
                21: t = 32'd326;
                22: t = 32'd163;
                23: t = 32'd81;
                24: t = 32'd41;
                25: t = 32'd20;
                26: t = 32'd10;
                27: t = 32'd5;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

endpackage

>>> rtl/voxel_phase_colourizer_top.sv
// top level of the voxel phase colourizer: config registers, pipeline and stream ports
//
// One RGBA word per voxel word, at up to one voxel per clock. An accepted input word passes
// to its output word through one entry stage, 28 cordic iterations (one per stage), and
// three stages for angle rounding, wheel ramps and the final colour register. Every stage
// holds its own valid bit; a stage loads whenever it or any stage behind it toward the
// output is empty, so bubbles collapse under back-pressure and a new word is taken while
// a finished one still waits on the output. Config writes are always taken and must only
// be issued while the pipeline is empty.
module voxel_phase_colourizer_top #(
    parameter int FIELD_WIDTH = 16,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, field_u, field_v, zero pad
    input  logic [((3*vpc_pkg::COORD_W+2*FIELD_WIDTH+7)/8)*8-1:0] s_tdata,
    // is_active, is_centre, in_bubble
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red, green, blue, alpha
    output logic [31:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vpc_pkg::*;

    localparam int NSTAGE = 1 + CORDIC_STEPS + 3;
    localparam int CW     = COORD_W;
    localparam int FW     = FIELD_WIDTH;

    logic              phase_enable_reg;
    slice_t            slice_mode_reg;
    logic [CW-1:0]     slice_x_reg;
    logic [CW-1:0]     slice_y_reg;
    logic [CW-1:0]     slice_z_reg;
    logic [CW-1:0]     centre_reg;
    logic [7:0]        radius_reg;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] load;

    cordic_t           cq [0:CORDIC_STEPS];
    rgba_t             rgba;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_enable_reg <= 1'b0;
            slice_mode_reg   <= SLICE_FULL;
            slice_x_reg      <= '0;
            slice_y_reg      <= '0;
            slice_z_reg      <= '0;
            centre_reg       <= CW'(64);
            radius_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PHASE_ENABLE:  phase_enable_reg <= cfg_data[0];
                CFG_SLICE_MODE:    slice_mode_reg   <= slice_t'(cfg_data[1:0]);
                CFG_SLICE_X:       slice_x_reg      <= cfg_data[CW-1:0];
                CFG_SLICE_Y:       slice_y_reg      <= cfg_data[CW-1:0];
                CFG_SLICE_Z:       slice_z_reg      <= cfg_data[CW-1:0];
                CFG_CENTRE_COORD:  centre_reg       <= cfg_data[CW-1:0];
                CFG_MARKER_RADIUS: radius_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // a stage loads when it, or any stage after it, is empty or the output drains
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_load
        assign load[k] = m_tready || !(&valid_reg[NSTAGE-1:k]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
            valid_next[0] = s_tvalid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (load[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[NSTAGE-1];

    vpc_front #(
        .FIELD_WIDTH(FIELD_WIDTH)
    ) u_front (
        .clk                 (clk),
        .en                  (load[0]),
        .pos_x               (s_tdata[CW-1:0]),
        .pos_y               (s_tdata[2*CW-1:CW]),
        .pos_z               (s_tdata[3*CW-1:2*CW]),
        .field_u             (s_tdata[3*CW+FW-1:3*CW]),
        .field_v             (s_tdata[3*CW+2*FW-1:3*CW+FW]),
        .is_active           (s_tuser[0]),
        .is_centre           (s_tuser[1]),
        .in_bubble           (s_tuser[2]),
        .phase_colour_enable (phase_enable_reg),
        .slice_mode          (slice_mode_reg),
        .slice_x             (slice_x_reg),
        .slice_y             (slice_y_reg),
        .slice_z             (slice_z_reg),
        .centre_coord        (centre_reg),
        .marker_radius       (radius_reg),
        .q                   (cq[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        vpc_cordic_stage #(
            .STEP(i)
        ) u_stage (
            .clk (clk),
            .en  (load[i+1]),
            .d   (cq[i]),
            .q   (cq[i+1])
        );
    end

    vpc_hue #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_hue (
        .clk (clk),
        .en  (load[NSTAGE-1:NSTAGE-3]),
        .d   (cq[CORDIC_STEPS]),
        .q   (rgba)
    );

    assign m_tdata = {rgba.alpha, rgba.blue, rgba.green, rgba.red};

endmodule

>>> rtl/vpc_front.sv
// entry stage: slice test, overlay priority and cordic pre-rotation
module vpc_front #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [vpc_pkg::COORD_W-1:0]    pos_x,
    input  logic [vpc_pkg::COORD_W-1:0]    pos_y,
    input  logic [vpc_pkg::COORD_W-1:0]    pos_z,
    input  logic signed [FIELD_WIDTH-1:0]  field_u,
    input  logic signed [FIELD_WIDTH-1:0]  field_v,
    input  logic                           is_active,
    input  logic                           is_centre,
    input  logic                           in_bubble,
    input  logic                           phase_colour_enable,
    input  vpc_pkg::slice_t                slice_mode,
    input  logic [vpc_pkg::COORD_W-1:0]    slice_x,
    input  logic [vpc_pkg::COORD_W-1:0]    slice_y,
    input  logic [vpc_pkg::COORD_W-1:0]    slice_z,
    input  logic [vpc_pkg::COORD_W-1:0]    centre_coord,
    input  logic [7:0]                     marker_radius,
    output vpc_pkg::cordic_t               q
);
    import vpc_pkg::*;

    localparam int PRE_SHIFT = 60 - FIELD_WIDTH;

    logic                   visible;
    logic                   marker;
    logic [8:0]             marker_x;
    logic                   u_pos;
    logic                   nonzero;
    logic signed [XY_W-1:0] u_sh;
    logic signed [XY_W-1:0] v_sh;
    cordic_t                q_reg;
    cordic_t                q_next;

    always_comb
    begin
        unique case (slice_mode)
            SLICE_XY: visible = (pos_z == slice_z);
            SLICE_YZ: visible = (pos_x == slice_x);
            SLICE_ZX: visible = (pos_y == slice_y);
            default:  visible = 1'b1;
        endcase
    end

    assign marker_x = {2'b00, centre_coord} + {1'b0, marker_radius};
    assign marker   = ({2'b00, pos_x} == marker_x) && (pos_y == centre_coord)
                      && (pos_z == centre_coord);
    assign nonzero  = (field_u != '0) || (field_v != '0);
    assign u_pos    = !field_u[FIELD_WIDTH-1] && (field_u != '0);
    assign u_sh     = XY_W'(field_u) <<< PRE_SHIFT;
    assign v_sh     = XY_W'(field_v) <<< PRE_SHIFT;

    always_comb
    begin
        q_next = q_reg;
        // vector (-u,-v) folded into the right half plane
        if (u_pos)
        begin
            q_next.x   = u_sh;
            q_next.y   = v_sh;
            q_next.acc = 32'h8000_0000;
        end
        else
        begin
            q_next.x   = -u_sh;
            q_next.y   = -v_sh;
            q_next.acc = 32'h0000_0000;
        end
        q_next.side.hue_en = visible && phase_colour_enable && in_bubble && nonzero;
        priority if (!visible)
            q_next.side.ov = OV_HIDE;
        else if (marker)
            q_next.side.ov = OV_RED;
        else if (is_centre)
            q_next.side.ov = OV_GREEN;
        else if (is_active)
            q_next.side.ov = OV_WHITE;
        else
            q_next.side.ov = OV_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/vpc_cordic_stage.sv
// one vectoring iteration of the cordic angle pipeline
module vpc_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  vpc_pkg::cordic_t d,
    output vpc_pkg::cordic_t q
);
    import vpc_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    cordic_t                q_reg;
    cordic_t                q_next;

    assign dx = d.y >>> STEP;
    assign dy = d.x >>> STEP;

    always_comb
    begin
        q_next      = d;
        if (d.y > 0)
        begin
            q_next.x   = d.x + dx;
            q_next.y   = d.y - dy;
            q_next.acc = d.acc + atan_turn(STEP);
        end
        else
        begin
            q_next.x   = d.x - dx;
            q_next.y   = d.y + dy;
            q_next.acc = d.acc - atan_turn(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/vpc_hue.sv
// angle rounding, colour wheel ramps and final colour select
module vpc_hue #(
    parameter int ANGLE_BITS = 16
) (
    input  logic             clk,
    input  logic [2:0]       en,
    input  vpc_pkg::cordic_t d,
    output vpc_pkg::rgba_t   q
);
    import vpc_pkg::*;

    localparam int AB = ANGLE_BITS;

    logic [32:0]   round_sum;
    logic [AB-1:0] angle;
    logic [AB+2:0] p;
    logic [2:0]    seg_reg;
    logic [AB-1:0] f_reg;
    side_t         side_a_reg;

    logic [AB:0]   g;
    logic [AB+7:0] rise_full;
    logic [AB+7:0] fall_full;
    logic [2:0]    seg_b_reg;
    logic [7:0]    rise_reg;
    logic [7:0]    fall_reg;
    side_t         side_b_reg;

    rgba_t         hue;
    rgba_t         q_reg;
    rgba_t         q_next;

    // round half up to the angle width, full turn wraps
    assign round_sum = {1'b0, d.acc} + (33'd1 << (31 - AB));
    assign angle     = round_sum[31 -: AB];
    assign p         = {1'b0, angle, 2'b00} + {2'b00, angle, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            seg_reg    <= p[AB+2:AB];
            f_reg      <= p[AB-1:0];
            side_a_reg <= d.side;
        end
    end

    assign g         = (AB+1)'(1) << AB;
    assign rise_full = {f_reg, 8'd0} - (AB+8)'(f_reg) + ((AB+8)'(1) << (AB - 1));
    assign fall_full = {(g - {1'b0, f_reg}), 7'd0} + {(g - {1'b0, f_reg}), 7'd0}
                       - (AB+8)'(g - {1'b0, f_reg}) + ((AB+8)'(1) << (AB - 1));

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            seg_b_reg  <= seg_reg;
            rise_reg   <= rise_full[AB+7:AB];
            fall_reg   <= fall_full[AB+7:AB];
            side_b_reg <= side_a_reg;
        end
    end

    always_comb
    begin
        hue.alpha = 8'd255;
        unique case (seg_b_reg)
            3'd0:
            begin
                hue.red = 8'd255;    hue.green = rise_reg; hue.blue = 8'd0;
            end
            3'd1:
            begin
                hue.red = fall_reg;  hue.green = 8'd255;   hue.blue = 8'd0;
            end
            3'd2:
            begin
                hue.red = 8'd0;      hue.green = 8'd255;   hue.blue = rise_reg;
            end
            3'd3:
            begin
                hue.red = 8'd0;      hue.green = fall_reg; hue.blue = 8'd255;
            end
            3'd4:
            begin
                hue.red = rise_reg;  hue.green = 8'd0;     hue.blue = 8'd255;
            end
            default:
            begin
                hue.red = 8'd255;    hue.green = 8'd0;     hue.blue = fall_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (side_b_reg.ov)
            OV_RED:   q_next = {8'd255, 8'd80, 8'd80, 8'd255};
            OV_GREEN: q_next = {8'd80, 8'd255, 8'd80, 8'd255};
            OV_WHITE: q_next = {8'd255, 8'd255, 8'd255, 8'd255};
            OV_NONE:  q_next = side_b_reg.hue_en ? hue : '0;
            default:  q_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
